FILE: hw/rtl/estimator_variance_health_monitor_core_assert.svh
// ----------------------------------------------------------------------------
// estimator variance health monitor - assertion macros
// shared property forms for the monitor's concurrent checks
// ----------------------------------------------------------------------------
`ifndef ESTIMATOR_VARIANCE_HEALTH_MONITOR_CORE_ASSERT_SVH
`define ESTIMATOR_VARIANCE_HEALTH_MONITOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EVHM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define EVHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/evhm_pkg.sv
// ----------------------------------------------------------------------------
// evhm_pkg
// types and constants shared by the variance health monitor modules
// ----------------------------------------------------------------------------
package evhm_pkg;

    // field widths
    localparam int VAR_W  = 16;
    localparam int CNT_W  = 8;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_VARIANCE_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FAIL_LIMIT         = 2'd1;
    localparam logic [IDX_W-1:0] CFG_WARN_INTERVAL_MS   = 2'd2;

    // configuration reset values
    localparam logic [VAR_W-1:0]  THRESHOLD_RST     = 16'd205;
    localparam logic [CNT_W-1:0]  FAIL_LIMIT_RST    = 8'd10;
    localparam logic [TIME_W-1:0] WARN_INTERVAL_RST = 32'd30000;

    // saturation point of the persistence counter
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // one input item as held in the input register
    typedef struct packed {
        logic              origin_known;
        logic              var_valid;
        logic [VAR_W-1:0]  mag_var_x;
        logic [VAR_W-1:0]  mag_var_y;
        logic [VAR_W-1:0]  mag_var_z;
        logic [VAR_W-1:0]  vel_var;
        logic [VAR_W-1:0]  pos_var;
        logic              flow_ok;
        logic              pos_known;
        logic [TIME_W-1:0] now_ms;
    } evhm_item_t;

    // one result item
    typedef struct packed {
        logic variance_bad;
        logic var_over;
        logic yaw_reset_request;
        logic lane_switch_request;
        logic failsafe_raise;
        logic failsafe_clear;
        logic warn_send;
    } evhm_result_t;

    // status flags of the persistence logic
    typedef struct packed {
        logic bad_flag;
        logic failsafe_active;
    } evhm_status_t;

endpackage

FILE: hw/rtl/estimator_variance_health_monitor_core.sv
// ----------------------------------------------------------------------------
// estimator_variance_health_monitor_core
// per-tick variance vote with persistence counter and failsafe pulses
// ----------------------------------------------------------------------------
// One tick goes in on the s_ channel and exactly one result comes out on the
// m_ channel, in order. A tick is captured into an input register, judged and
// applied to the counter state as it moves on into an output register, which
// holds its result until the receiver takes it. A new tick is taken every
// cycle while results are drained, as the next state is combinational between
// the two registers. Write the configuration registers (index 0 threshold,
// 1 fail limit, 2 warning interval) only while no tick is in flight.
module estimator_variance_health_monitor_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration
    input  logic                             cfg_we,
    input  logic [evhm_pkg::IDX_W-1:0]       cfg_index,
    input  logic [evhm_pkg::CFG_W-1:0]       cfg_wdata,
    // tick input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_origin_known,
    input  logic                             s_var_valid,
    input  logic [evhm_pkg::VAR_W-1:0]       s_mag_var_x,
    input  logic [evhm_pkg::VAR_W-1:0]       s_mag_var_y,
    input  logic [evhm_pkg::VAR_W-1:0]       s_mag_var_z,
    input  logic [evhm_pkg::VAR_W-1:0]       s_vel_var,
    input  logic [evhm_pkg::VAR_W-1:0]       s_pos_var,
    input  logic                             s_flow_ok,
    input  logic                             s_pos_known,
    input  logic [evhm_pkg::TIME_W-1:0]      s_now_ms,
    // result output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_variance_bad,
    output logic                             m_var_over,
    output logic                             m_yaw_reset_request,
    output logic                             m_lane_switch_request,
    output logic                             m_failsafe_raise,
    output logic                             m_failsafe_clear,
    output logic                             m_warn_send
);
    import evhm_pkg::*;

    logic [VAR_W-1:0]  threshold_reg;
    logic [CNT_W-1:0]  fail_limit_reg;
    logic [TIME_W-1:0] warn_interval_reg;

    logic              in_valid_reg;
    logic              in_valid_next;
    evhm_item_t        item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    evhm_result_t      out_reg;

    logic              s_xfer;
    logic              advance;
    logic              over;
    evhm_result_t      res;
    evhm_status_t      status;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg     <= THRESHOLD_RST;
            fail_limit_reg    <= FAIL_LIMIT_RST;
            warn_interval_reg <= WARN_INTERVAL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_VARIANCE_THRESHOLD: threshold_reg     <= cfg_wdata[VAR_W-1:0];
                CFG_FAIL_LIMIT:         fail_limit_reg    <= cfg_wdata[CNT_W-1:0];
                CFG_WARN_INTERVAL_MS:   warn_interval_reg <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign s_xfer         = s_valid && s_ready;
    assign in_valid_next  = s_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            item_reg.origin_known <= s_origin_known;
            item_reg.var_valid    <= s_var_valid;
            item_reg.mag_var_x    <= s_mag_var_x;
            item_reg.mag_var_y    <= s_mag_var_y;
            item_reg.mag_var_z    <= s_mag_var_z;
            item_reg.vel_var      <= s_vel_var;
            item_reg.pos_var      <= s_pos_var;
            item_reg.flow_ok      <= s_flow_ok;
            item_reg.pos_known    <= s_pos_known;
            item_reg.now_ms       <= s_now_ms;
        end
    end

    // variance vote
    evhm_vote u_vote (
        .item      (item_reg),
        .threshold (threshold_reg),
        .over      (over)
    );

    // persistence and failsafe state
    evhm_state u_state (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (advance),
        .item             (item_reg),
        .over             (over),
        .threshold        (threshold_reg),
        .fail_limit       (fail_limit_reg),
        .warn_interval_ms (warn_interval_reg),
        .res              (res),
        .status           (status)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_variance_bad        = out_reg.variance_bad;
    assign m_var_over            = out_reg.var_over;
    assign m_yaw_reset_request   = out_reg.yaw_reset_request;
    assign m_lane_switch_request = out_reg.lane_switch_request;
    assign m_failsafe_raise      = out_reg.failsafe_raise;
    assign m_failsafe_clear      = out_reg.failsafe_clear;
    assign m_warn_send           = out_reg.warn_send;

    // checks
`include "estimator_variance_health_monitor_core_assert.svh"

    `EVHM_ASSERT_IMP(a_fs_bad, 1'b1, status.failsafe_active == status.bad_flag, "fs mismatch")
    `EVHM_ASSERT_IMP(a_raise_bad, m_valid && m_failsafe_raise, m_variance_bad, "raise w/o bad")
    `EVHM_ASSERT_IMP(a_warn_raise, m_valid && m_warn_send, m_failsafe_raise, "warn w/o raise")
    `EVHM_ASSERT_NEXT(a_clr, advance && res.failsafe_clear, !status.bad_flag, "bad after clear")

endmodule

FILE: hw/rtl/evhm_vote.sv
// ----------------------------------------------------------------------------
// evhm_vote
// votes compass, velocity and position variances against the threshold
// ----------------------------------------------------------------------------
module evhm_vote (
    input  evhm_pkg::evhm_item_t     item,
    input  logic [evhm_pkg::VAR_W-1:0] threshold,
    output logic                     over
);
    import evhm_pkg::*;

    logic [VAR_W-1:0] mag_xy;
    logic [VAR_W-1:0] mag_max;
    logic             mag_hit;
    logic             vel_hit;
    logic             vel_double_hit;
    logic             pos_hit;
    logic             any_hit;
    logic             two_hits;

    // largest compass axis
    assign mag_xy  = (item.mag_var_y > item.mag_var_x) ? item.mag_var_y : item.mag_var_x;
    assign mag_max = (item.mag_var_z > mag_xy) ? item.mag_var_z : mag_xy;

    // single compares
    assign mag_hit = (mag_max >= threshold);
    assign vel_hit = (item.vel_var >= threshold);
    assign pos_hit = (item.pos_var >= threshold);

    // double threshold on 17 bits, only without healthy optical flow
    assign vel_double_hit = !item.flow_ok &&
                            ({1'b0, item.vel_var} >= {threshold, 1'b0});

    // vote count of at least one and of at least two
    assign any_hit  = mag_hit || vel_hit;
    assign two_hits = vel_double_hit || (mag_hit && vel_hit);

    // final decision, disabled by invalid variances or zero threshold
    assign over = item.var_valid && (threshold != '0) &&
                  ((pos_hit && any_hit) || two_hits);

endmodule

FILE: hw/rtl/evhm_state.sv
// ----------------------------------------------------------------------------
// evhm_state
// persistence counter, bad flag, failsafe latch and warning throttle
// ----------------------------------------------------------------------------
module evhm_state (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  evhm_pkg::evhm_item_t          item,
    input  logic                          over,
    input  logic [evhm_pkg::VAR_W-1:0]    threshold,
    input  logic [evhm_pkg::CNT_W-1:0]    fail_limit,
    input  logic [evhm_pkg::TIME_W-1:0]   warn_interval_ms,
    output evhm_pkg::evhm_result_t        res,
    output evhm_pkg::evhm_status_t        status
);
    import evhm_pkg::*;

    logic [CNT_W-1:0]  fail_counter_reg;
    logic [CNT_W-1:0]  fail_counter_next;
    logic              bad_flag_reg;
    logic              bad_flag_next;
    logic              ever_passed_reg;
    logic              ever_passed_next;
    logic [TIME_W-1:0] last_warn_ms_reg;
    logic [TIME_W-1:0] last_warn_ms_next;
    logic              failsafe_active_reg;
    logic              failsafe_active_next;

    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_dec;
    logic [CNT_W-1:0]  limit_m1;
    logic [CNT_W-1:0]  limit_m2;
    logic [TIME_W-1:0] since_warn;
    logic              warn_due;
    logic              passed;

    // counter steps and limit marks; the increment saturates at CNT_MAX, the rest wrap like 8-bit arithmetic
    assign cnt_inc    = (fail_counter_reg == CNT_MAX) ? fail_counter_reg
                                                      : fail_counter_reg + 8'd1;
    assign cnt_dec    = fail_counter_reg - 8'd1;
    assign limit_m1   = fail_limit - 8'd1;
    assign limit_m2   = fail_limit - 8'd2;
    assign since_warn = item.now_ms - last_warn_ms_reg;
    assign warn_due   = (since_warn > warn_interval_ms);
    assign passed     = !over && item.pos_known;

    // next state and result pulses for one tick
    always_comb begin
        fail_counter_next    = fail_counter_reg;
        bad_flag_next        = bad_flag_reg;
        ever_passed_next     = ever_passed_reg;
        last_warn_ms_next    = last_warn_ms_reg;
        failsafe_active_next = failsafe_active_reg;
        res                  = '0;
        if (item.origin_known) begin
            if (threshold == '0) begin
                // check disabled: clear the counter, the bad flag and the failsafe
                fail_counter_next = '0;
                bad_flag_next     = 1'b0;
                if (failsafe_active_reg) begin
                    failsafe_active_next = 1'b0;
                    res.failsafe_clear   = 1'b1;
                end
            end else begin
                res.var_over = over;
                if (passed) begin
                    ever_passed_next = 1'b1;
                end
                if (ever_passed_reg || passed) begin
                    if (!passed) begin
                        if (!bad_flag_reg) begin
                            // count up toward the failure declaration
                            fail_counter_next       = cnt_inc;
                            res.yaw_reset_request   = (cnt_inc == limit_m2) && over;
                            res.lane_switch_request = (cnt_inc == limit_m1);
                            if (cnt_inc >= fail_limit) begin
                                fail_counter_next    = fail_limit;
                                bad_flag_next        = 1'b1;
                                failsafe_active_next = 1'b1;
                                res.failsafe_raise   = 1'b1;
                                if (warn_due) begin
                                    res.warn_send     = 1'b1;
                                    last_warn_ms_next = item.now_ms;
                                end
                            end
                        end
                    end else if (fail_counter_reg != '0) begin
                        // decay, clear the failure at zero
                        fail_counter_next = cnt_dec;
                        if (bad_flag_reg && (cnt_dec == '0)) begin
                            bad_flag_next = 1'b0;
                            if (failsafe_active_reg) begin
                                failsafe_active_next = 1'b0;
                                res.failsafe_clear   = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        res.variance_bad = bad_flag_next;
    end

    // state registers, updated once per processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fail_counter_reg    <= '0;
            bad_flag_reg        <= 1'b0;
            ever_passed_reg     <= 1'b0;
            last_warn_ms_reg    <= '0;
            failsafe_active_reg <= 1'b0;
        end else if (step_en) begin
            fail_counter_reg    <= fail_counter_next;
            bad_flag_reg        <= bad_flag_next;
            ever_passed_reg     <= ever_passed_next;
            last_warn_ms_reg    <= last_warn_ms_next;
            failsafe_active_reg <= failsafe_active_next;
        end
    end

    assign status.bad_flag        = bad_flag_reg;
    assign status.failsafe_active = failsafe_active_reg;

endmodule

FILE: tb/tb_estimator_variance_health_monitor_core.sv
// ----------------------------------------------------------------------------
// tb_estimator_variance_health_monitor_core
// self-checking bench for the variance vote, persistence counter and pulses
// ----------------------------------------------------------------------------
// Ticks are driven over the s_ channel and every accepted tick is run through
// a cycle-free predictor of the vote, hysteresis counter, failsafe latch and
// warning throttle. Each result transfer on the m_ channel is checked field by
// field against the oldest prediction. A directed opening covers the reset
// settings, the vote cases, a full fail and recover cycle, limits below two
// and the disabled check; random phases then run fail and pass episodes
// under several register settings and idling patterns, including one long
// receiver hold-off that backs the block up into its input.
module tb_estimator_variance_health_monitor_core;
    timeunit 1ns;
    timeprecision 1ps;

    import evhm_pkg::*;

    // prediction of the block and store of expected results
    class variance_health_scoreboard;
        logic [VAR_W-1:0]  threshold_q88;
        logic [CNT_W-1:0]  persist_limit;
        logic [TIME_W-1:0] warn_gap_ms;
        logic [CNT_W-1:0]  persist_count;
        logic [TIME_W-1:0] warn_stamp_ms;
        bit                flagged_bad;
        bit                seen_pass;
        bit                fs_latched;
        evhm_result_t      expected_q[$];
        int                mismatches;
        int                results_seen;
        string             field_names[7];

        function new();
            threshold_q88 = THRESHOLD_RST;
            persist_limit = FAIL_LIMIT_RST;
            warn_gap_ms   = WARN_INTERVAL_RST;
            persist_count = '0;
            warn_stamp_ms = '0;
            flagged_bad   = 1'b0;
            seen_pass     = 1'b0;
            fs_latched    = 1'b0;
            mismatches    = 0;
            results_seen  = 0;
            // indexed by bit position in the packed result
            field_names = '{"warn_send", "failsafe_clear", "failsafe_raise",
                            "lane_switch_request", "yaw_reset_request",
                            "var_over", "variance_bad"};
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_VARIANCE_THRESHOLD: threshold_q88 = data[VAR_W-1:0];
                CFG_FAIL_LIMIT:         persist_limit = data[CNT_W-1:0];
                CFG_WARN_INTERVAL_MS:   warn_gap_ms   = data[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        // compass, velocity and position vote
        function bit majority_over(evhm_item_t k);
            logic [VAR_W-1:0] peak;
            int               votes;
            if (!k.var_valid || threshold_q88 == '0) return 1'b0;
            peak = k.mag_var_x;
            if (k.mag_var_y > peak) peak = k.mag_var_y;
            if (k.mag_var_z > peak) peak = k.mag_var_z;
            votes = 0;
            if (peak >= threshold_q88) votes++;
            // doubled threshold compared on 17 bits
            if (!k.flow_ok && {1'b0, k.vel_var} >= {threshold_q88, 1'b0})
                votes += 2;
            else if (k.vel_var >= threshold_q88)
                votes++;
            return (k.pos_var >= threshold_q88 && votes >= 1) || votes >= 2;
        endfunction

        function void note_tick(evhm_item_t k);
            evhm_result_t r;
            bit           passed;
            r = '0;
            if (k.origin_known) begin
                if (threshold_q88 == '0) begin
                    // check disabled: counter and flag forced clear
                    persist_count = '0;
                    flagged_bad   = 1'b0;
                    if (fs_latched) begin
                        fs_latched       = 1'b0;
                        r.failsafe_clear = 1'b1;
                    end
                end else begin
                    r.var_over = majority_over(k);
                    passed = !r.var_over && k.pos_known;
                    if (passed) seen_pass = 1'b1;
                    if (seen_pass) begin
                        if (!passed) begin
                            if (!flagged_bad) begin
                                if (persist_count != CNT_MAX) persist_count++;
                                if (persist_count == persist_limit - 8'd2 && r.var_over)
                                    r.yaw_reset_request = 1'b1;
                                if (persist_count == persist_limit - 8'd1)
                                    r.lane_switch_request = 1'b1;
                                if (persist_count >= persist_limit) begin
                                    persist_count = persist_limit;
                                    flagged_bad   = 1'b1;
                                    // throttled warning, wrapping time difference
                                    if (k.now_ms - warn_stamp_ms > warn_gap_ms) begin
                                        r.warn_send   = 1'b1;
                                        warn_stamp_ms = k.now_ms;
                                    end
                                    fs_latched       = 1'b1;
                                    r.failsafe_raise = 1'b1;
                                end
                            end
                        end else if (persist_count != '0) begin
                            persist_count--;
                            if (flagged_bad && persist_count == '0) begin
                                flagged_bad = 1'b0;
                                if (fs_latched) begin
                                    fs_latched       = 1'b0;
                                    r.failsafe_clear = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            r.variance_bad = flagged_bad;
            expected_q.push_back(r);
        endfunction

        function void check_result(evhm_result_t got);
            evhm_result_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %b arrived with no tick outstanding",
                             results_seen, got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    for (int i = 0; i < 7; i++)
                        if (got[i] !== want[i])
                            $display("result %0d: %s expected %0b got %0b",
                                     results_seen, field_names[i], want[i], got[i]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // block ports
    logic                aclk;
    logic                aresetn               = 1'b0;
    logic                cfg_we                = 1'b0;
    logic [IDX_W-1:0]    cfg_index             = CFG_VARIANCE_THRESHOLD;
    logic [CFG_W-1:0]    cfg_wdata             = '0;
    logic                s_valid               = 1'b0;
    logic                s_ready;
    logic                s_origin_known        = 1'b0;
    logic                s_var_valid           = 1'b0;
    logic [VAR_W-1:0]    s_mag_var_x           = '0;
    logic [VAR_W-1:0]    s_mag_var_y           = '0;
    logic [VAR_W-1:0]    s_mag_var_z           = '0;
    logic [VAR_W-1:0]    s_vel_var             = '0;
    logic [VAR_W-1:0]    s_pos_var             = '0;
    logic                s_flow_ok             = 1'b0;
    logic                s_pos_known           = 1'b0;
    logic [TIME_W-1:0]   s_now_ms              = '0;
    logic                m_valid;
    logic                m_ready               = 1'b0;
    logic                m_variance_bad;
    logic                m_var_over;
    logic                m_yaw_reset_request;
    logic                m_lane_switch_request;
    logic                m_failsafe_raise;
    logic                m_failsafe_clear;
    logic                m_warn_send;

    variance_health_scoreboard health_sb = new();

    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_left     = 0;
    logic [TIME_W-1:0] ms_clock      = '0;

    estimator_variance_health_monitor_core dut (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #5ms;
        $display("estimator_variance_health_monitor_core regression: fail");
        $finish;
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // note each input transfer, then check each result transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                health_sb.note_tick('{s_origin_known, s_var_valid, s_mag_var_x,
                                      s_mag_var_y, s_mag_var_z, s_vel_var, s_pos_var,
                                      s_flow_ok, s_pos_known, s_now_ms});
            if (m_valid && m_ready)
                health_sb.check_result('{m_variance_bad, m_var_over,
                                         m_yaw_reset_request, m_lane_switch_request,
                                         m_failsafe_raise, m_failsafe_clear,
                                         m_warn_send});
        end
    end

    // offer one tick, with a random gap first, and wait for its transfer
    task automatic send_tick(input evhm_item_t k);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_origin_known <= k.origin_known;
        s_var_valid    <= k.var_valid;
        s_mag_var_x    <= k.mag_var_x;
        s_mag_var_y    <= k.mag_var_y;
        s_mag_var_z    <= k.mag_var_z;
        s_vel_var      <= k.vel_var;
        s_pos_var      <= k.pos_var;
        s_flow_ok      <= k.flow_ok;
        s_pos_known    <= k.pos_known;
        s_now_ms       <= k.now_ms;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait until every result is back
    task automatic drain_ticks();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (health_sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write all three registers while the block is idle
    task automatic program_regs(input logic [VAR_W-1:0] thr, input logic [CNT_W-1:0] lim,
                                input logic [TIME_W-1:0] gap_ms);
        drain_ticks();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VARIANCE_THRESHOLD;
        cfg_wdata <= CFG_W'(thr);
        @(posedge aclk);
        health_sb.write_reg(CFG_VARIANCE_THRESHOLD, CFG_W'(thr));
        cfg_index <= CFG_FAIL_LIMIT;
        cfg_wdata <= CFG_W'(lim);
        @(posedge aclk);
        health_sb.write_reg(CFG_FAIL_LIMIT, CFG_W'(lim));
        cfg_index <= CFG_WARN_INTERVAL_MS;
        cfg_wdata <= gap_ms;
        @(posedge aclk);
        health_sb.write_reg(CFG_WARN_INTERVAL_MS, gap_ms);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic evhm_item_t tick_of(bit org, bit vv, logic [VAR_W-1:0] mx,
                                          logic [VAR_W-1:0] my, logic [VAR_W-1:0] mz,
                                          logic [VAR_W-1:0] vel, logic [VAR_W-1:0] pos,
                                          bit flow, bit hp, logic [TIME_W-1:0] now);
        return '{org, vv, mx, my, mz, vel, pos, flow, hp, now};
    endfunction

    // values at or above the threshold, doubled threshold among them
    function automatic logic [VAR_W-1:0] above_thr(logic [VAR_W-1:0] t);
        case ($urandom_range(0, 3))
            0:       return t;
            1:       return 16'hFFFF;
            2:       return VAR_W'($urandom_range(t, 16'hFFFF));
            default: return (t <= 16'h7FFF) ? (t << 1) : 16'hFFFF;
        endcase
    endfunction

    // values below the threshold
    function automatic logic [VAR_W-1:0] below_thr(logic [VAR_W-1:0] t);
        if (t == '0) return '0;
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return t - 16'd1;
            default: return VAR_W'($urandom_range(0, t - 1));
        endcase
    endfunction

    // wrapping millisecond time with an occasional jump
    function automatic logic [TIME_W-1:0] next_ms();
        if ($urandom_range(0, 49) == 0) ms_clock = $urandom;
        else ms_clock = ms_clock + $urandom_range(0, 3000);
        return ms_clock;
    endfunction

    // tick shaped to fail or to pass the check, or plain noise
    function automatic evhm_item_t make_tick(bit want_fail);
        evhm_item_t       k;
        logic [VAR_W-1:0] t;
        int               axis;
        t = health_sb.threshold_q88;
        k.now_ms = next_ms();
        if ($urandom_range(0, 9) == 0) begin
            k.origin_known = 1'($urandom_range(0, 1));
            k.var_valid    = 1'($urandom_range(0, 1));
            k.mag_var_x    = VAR_W'($urandom);
            k.mag_var_y    = VAR_W'($urandom);
            k.mag_var_z    = VAR_W'($urandom);
            k.vel_var      = VAR_W'($urandom);
            k.pos_var      = VAR_W'($urandom);
            k.flow_ok      = 1'($urandom_range(0, 1));
            k.pos_known    = 1'($urandom_range(0, 1));
            return k;
        end
        k.origin_known = ($urandom_range(0, 29) != 0);
        k.var_valid    = ($urandom_range(0, 19) != 0);
        k.flow_ok      = 1'($urandom_range(0, 1));
        k.mag_var_x    = below_thr(t);
        k.mag_var_y    = below_thr(t);
        k.mag_var_z    = below_thr(t);
        k.vel_var      = below_thr(t);
        k.pos_var      = below_thr(t);
        k.pos_known    = ($urandom_range(0, 9) != 0);
        if (want_fail) begin
            axis = $urandom_range(0, 2);
            k.pos_known = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0, 1: begin
                    if (axis == 0) k.mag_var_x = above_thr(t);
                    else if (axis == 1) k.mag_var_y = above_thr(t);
                    else k.mag_var_z = above_thr(t);
                    if ($urandom_range(0, 1)) k.pos_var = above_thr(t);
                    else k.vel_var = above_thr(t);
                end
                2: begin
                    k.vel_var = above_thr(t);
                    k.flow_ok = 1'b0;
                end
                default: k.pos_known = 1'b0;
            endcase
        end
        return k;
    endfunction

    // fail and pass episodes sized around the limit
    task automatic run_ticks(input int n);
        int done;
        int lim;
        int fail_len;
        int pass_len;
        done = 0;
        while (done < n) begin
            lim = (health_sb.persist_limit < 2) ? 2 : health_sb.persist_limit;
            fail_len = $urandom_range(0, 1) ? $urandom_range(lim - 2, lim + 2)
                                            : $urandom_range(1, lim + 2);
            pass_len = $urandom_range(0, 1) ? $urandom_range(lim - 2, lim + 2)
                                            : $urandom_range(1, lim + 2);
            for (int i = 0; i < fail_len && done < n; i++, done++)
                send_tick(make_tick(1'b1));
            for (int i = 0; i < pass_len && done < n; i++, done++)
                send_tick(make_tick(1'b0));
        end
    endtask

    // main sequence
    initial begin
        send_idle_pct = 38;
        recv_idle_pct = 53;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: skipped tick, fails before any pass, vote cases
        send_tick(tick_of(0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          1, 1, 32'hFFFF_FFFF));
        send_tick(tick_of(1, 1, 16'hFFFF, 0, 0, 0, 16'hFFFF, 0, 1, 100));
        send_tick(tick_of(1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          0, 0, 200));
        send_tick(tick_of(1, 1, 0, 0, 0, 410, 0, 0, 1, 300));
        send_tick(tick_of(1, 1, 0, 0, 0, 410, 0, 1, 1, 400));
        // persistent failure up to the limit, then once more while bad
        for (int i = 0; i < 11; i++) begin
            if (i == 0)
                send_tick(tick_of(1, 1, 0, 0, 0, 409, 205, 0, 1, 1000));
            else
                send_tick(tick_of(1, 1, (i % 3 == 0) ? 16'hFFFF : 16'd0,
                                  (i % 3 == 1) ? 16'd205 : 16'd0,
                                  (i % 3 == 2) ? 16'hFFFF : 16'd0,
                                  0, 16'hFFFF, 0, 1, (i == 9) ? 30001 : 1000 * i));
        end
        // recovery back to zero
        for (int i = 0; i < 10; i++)
            send_tick(tick_of(1, 1, 204, 204, 204, 204, 204, 0, 1, 31000 + i));

        // limit of one, then the disabled check clears the failsafe
        program_regs(205, 1, 30000);
        send_tick(tick_of(1, 1, 16'hFFFF, 0, 0, 0, 16'hFFFF, 0, 1, 40000));
        program_regs(0, 1, 30000);
        send_tick(tick_of(1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          0, 1, 40000));
        // limit of zero with no warning interval
        program_regs(205, 0, 0);
        send_tick(tick_of(1, 1, 0, 16'hFFFF, 0, 0, 16'hFFFF, 0, 1, 40001));
        send_tick(tick_of(1, 1, 0, 0, 0, 0, 0, 0, 1, 40002));
        program_regs(0, 0, 0);
        send_tick(tick_of(1, 1, 0, 0, 0, 0, 0, 0, 1, 40003));

        // random phases
        program_regs(205, 7, 0);
        run_ticks(150);
        program_regs(16'hFFFF, 12, 1000);
        run_ticks(150);
        send_idle_pct = 53;
        recv_idle_pct = 38;
        program_regs(1, 255, 32'hFFFF_FFFF);
        run_ticks(400);
        program_regs(VAR_W'($urandom_range(2, 40000)), CNT_W'($urandom_range(7, 20)),
                     $urandom_range(0, 5000));
        run_ticks(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_regs(0, 9, 30000);
        run_ticks(40);
        program_regs(300, 8, 20000);
        // long receiver hold-off so the block backs up into its input
        hold_left = 80;
        run_ticks(200);

        drain_ticks();
        if (health_sb.mismatches == 0)
            $display("estimator_variance_health_monitor_core regression: pass");
        else
            $display("estimator_variance_health_monitor_core regression: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/evhm_pkg.sv
hw/rtl/evhm_vote.sv
hw/rtl/evhm_state.sv
hw/rtl/estimator_variance_health_monitor_core.sv
tb/tb_estimator_variance_health_monitor_core.sv
